### rtl/arctangent_rational_approx_defines.svh
// assertion macros for the arctangent block
// used by files that include it; expects clk_i and rst_ni in scope
`ifndef ARCTANGENT_RATIONAL_APPROX_DEFINES_SVH
`define ARCTANGENT_RATIONAL_APPROX_DEFINES_SVH

// same-cycle implication
`define ARA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ara_pkg.sv
// shared types, constants and helpers for the arctangent pipeline
// no dependencies
package ara_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned OUT_W     = 18;

  // divider geometry
  localparam int unsigned DIV_NW     = 64;
  localparam int unsigned DIV_DW     = 32;
  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIV_STAGES = DIV_DW / DIV_BPS;

  localparam int unsigned HORNER_STEPS = 4;

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] TH_LO =
    32'(((64'd414213 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] TH_HI =
    32'(((64'd2414213 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] PI4_Q30 = 32'(((64'd785398 << 30) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] PI2_Q30 = 32'(((64'd1570796 << 30) + 64'd500000) / 64'd1000000);
  localparam logic [32:0] RND_HALF = 33'(64'd1 << (30 - FRAC_BITS - 1));

  // coefficients in Q.20, highest power first
  localparam logic [31:0] NUM_C [5] = '{
    32'(((64'd16153641   << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd268425481  << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd1153029351 << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd1780406316 << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd896785974  << 20) + 64'd500000) / 64'd1000000)
  };
  localparam logic [31:0] DEN_C [5] = '{
    32'(((64'd58956970   << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd536265374  << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd1666783814 << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd2079334974 << 20) + 64'd500000) / 64'd1000000),
    32'(((64'd896785974  << 20) + 64'd500000) / 64'd1000000)
  };

  typedef enum logic [1:0] {
    REG_SMALL,
    REG_LARGE,
    REG_MID
  } region_e;

  typedef struct packed {
    logic        neg;
    region_e     region;
    logic        tneg;
    logic [29:0] tm;
  } side_t;

  // v * s in Q30 with round to nearest
  function automatic logic [31:0] mul_s(input logic [31:0] v, input logic [29:0] s);
    logic [61:0] p;
    p = 62'(v) * 62'(s) + 62'(64'd1 << 29);
    return p[61:30];
  endfunction

endpackage

### rtl/arctangent_rational_approx.sv
// arctangent of a signed Q16.16 value by range reduction and a rational polynomial
// depends on ara_pkg, ara_div and arctangent_rational_approx_defines.svh
//
//  channel  dir  tdata fields (low bit up)        notes
//  s_axis   in   value_in [31:0] signed Q16.16    one transaction per argument
//  m_axis   out  angle [17:0] signed, pad to 24   one transaction per argument
//
// one argument per cycle while m_axis does not stall; registers in order: 16 divider stages for the
// reduced argument, square, four polynomial stages, 16 divider stages for the
// ratio, final product and the output register
// reset clears the valid bits only; payload registers are not reset
// a stall on m_axis freezes the whole pipeline, s_axis_tready_o drops with it
`include "arctangent_rational_approx_defines.svh"

module arctangent_rational_approx (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [17:0] angle, [23:18] zero
);

  localparam int unsigned NH = ara_pkg::HORNER_STEPS;

  logic en;

  // argument reduction
  logic           in_neg;
  logic [31:0]    in_mag;
  logic [31:0]    in_sum;
  logic [31:0]    in_x;
  logic [31:0]    in_den;
  logic [63:0]    in_num;
  ara_pkg::side_t in_side;

  // divider one
  logic           d1_vld;
  logic [31:0]    d1_quo;
  ara_pkg::side_t d1_side;

  // square
  logic           v1_q;
  logic [29:0]    s1_q;
  logic [31:0]    den0_q;
  ara_pkg::side_t side1_q;
  logic [59:0]    sq_prod;
  logic [29:0]    sq_val;

  // polynomial stages
  logic [NH-1:0]  hv_q;
  logic [31:0]    hn_q [NH];
  logic [31:0]    hn_d [NH];
  logic [31:0]    hd_q [NH];
  logic [31:0]    hd_d [NH];
  logic [29:0]    hs_q [NH];
  logic [29:0]    hs_d [NH];
  ara_pkg::side_t hside_q [NH];
  ara_pkg::side_t hside_d [NH];

  // divider two
  logic [63:0]    r_num;
  logic           d2_vld;
  logic [31:0]    d2_quo;
  ara_pkg::side_t d2_side;

  // final product and output
  logic           vf_q;
  logic [30:0]    pm_q;
  ara_pkg::side_t sidef_q;
  logic [60:0]    pm_prod;
  logic [31:0]    res;
  logic [32:0]    rnd;
  logic [17:0]    ang;
  logic           out_vld_q;
  logic [17:0]    out_ang_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    in_neg = s_axis_tdata_i[31];
    in_mag = in_neg ? (32'd0 - s_axis_tdata_i) : s_axis_tdata_i;
    if (in_mag[31]) begin
      in_mag = 32'h7FFF_FFFF;
    end
    in_sum          = in_mag + ara_pkg::ONE;
    in_side.neg     = in_neg;
    in_side.tneg    = 1'b0;
    in_side.tm      = '0;
    if (in_mag < ara_pkg::TH_LO) begin
      // exact scaling through a divide by one
      in_side.region = ara_pkg::REG_SMALL;
      in_x           = in_mag;
      in_den         = ara_pkg::ONE;
    end else if (in_mag > ara_pkg::TH_HI) begin
      in_side.region = ara_pkg::REG_LARGE;
      in_x           = ara_pkg::ONE;
      in_den         = in_mag;
    end else begin
      in_side.region = ara_pkg::REG_MID;
      in_den         = in_sum;
      if (in_mag >= ara_pkg::ONE) begin
        in_x = in_mag - ara_pkg::ONE;
      end else begin
        in_x         = ara_pkg::ONE - in_mag;
        in_side.tneg = 1'b1;
      end
    end
    in_num = ({32'd0, in_x} << 30) + {33'd0, in_den[31:1]};
  end

  ara_div u_div_arg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .num_i  (in_num),
    .den_i  (in_den),
    .side_i (in_side),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  assign sq_prod = 60'(d1_quo[29:0]) * 60'(d1_quo[29:0]) + 60'(64'd1 << 29);
  assign sq_val  = sq_prod[59:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      hv_q <= '0;
      vf_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= d1_vld;
      hv_q      <= {hv_q[NH-2:0], v1_q};
      vf_q      <= d2_vld;
      out_vld_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= sq_val;
      den0_q  <= 32'((33'(sq_val) + 33'd512) >> 10) + ara_pkg::DEN_C[0];
      side1_q <= '{neg: d1_side.neg, region: d1_side.region, tneg: d1_side.tneg,
                   tm: d1_quo[29:0]};
    end
  end

  always_comb begin
    logic [31:0] n, d;
    logic [29:0] s;
    ara_pkg::side_t sd;
    for (int k = 0; k < NH; k++) begin
      n  = (k == 0) ? ara_pkg::NUM_C[0] : hn_q[(k == 0) ? 0 : k-1];
      d  = (k == 0) ? den0_q            : hd_q[(k == 0) ? 0 : k-1];
      s  = (k == 0) ? s1_q              : hs_q[(k == 0) ? 0 : k-1];
      sd = (k == 0) ? side1_q           : hside_q[(k == 0) ? 0 : k-1];
      hn_d[k]    = ara_pkg::mul_s(n, s) + ara_pkg::NUM_C[k+1];
      hd_d[k]    = ara_pkg::mul_s(d, s) + ara_pkg::DEN_C[k+1];
      hs_d[k]    = s;
      hside_d[k] = sd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NH; k++) begin
        hn_q[k]    <= hn_d[k];
        hd_q[k]    <= hd_d[k];
        hs_q[k]    <= hs_d[k];
        hside_q[k] <= hside_d[k];
      end
    end
  end

  assign r_num = ({32'd0, hn_q[NH-1]} << 30) + {33'd0, hd_q[NH-1][31:1]};

  ara_div u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (hv_q[NH-1]),
    .num_i  (r_num),
    .den_i  (hd_q[NH-1]),
    .side_i (hside_q[NH-1]),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  assign pm_prod = 61'(d2_quo[30:0]) * 61'(d2_side.tm) + 61'(64'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q    <= pm_prod[60:30];
      sidef_q <= d2_side;
    end
  end

  always_comb begin
    case (sidef_q.region)
      ara_pkg::REG_SMALL: res = {1'b0, pm_q};
      ara_pkg::REG_LARGE: res = ara_pkg::PI2_Q30 - {1'b0, pm_q};
      ara_pkg::REG_MID: begin
        res = sidef_q.tneg ? (ara_pkg::PI4_Q30 - {1'b0, pm_q})
                           : (ara_pkg::PI4_Q30 + {1'b0, pm_q});
      end
      default: res = '0;
    endcase
    rnd = (33'(res) + ara_pkg::RND_HALF) >> (30 - ara_pkg::FRAC_BITS);
    ang = sidef_q.neg ? (18'd0 - rnd[17:0]) : rnd[17:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ang_q <= ang;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_ang_q};

  `ARA_ASSERT_IMP(a_tm_range, d1_vld, d1_quo[31:30] == 2'b00, "reduced argument out of range")
  `ARA_ASSERT_IMP(a_ratio_range, d2_vld,
    (d2_quo[31] == 1'b0) && ((d2_quo[30] == 1'b0) || (d2_quo[29:0] == 30'd0)),
    "polynomial ratio above one")
  `ARA_ASSERT_NXT(a_angle_range, en && vf_q,
    ($signed(out_ang_q) <= 18'sd102944) && ($signed(out_ang_q) >= -18'sd102944),
    "angle beyond pi/2")

endmodule

### rtl/ara_div.sv
// pipelined restoring divider, two quotient bits per stage
// depends on ara_pkg
module ara_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [ara_pkg::DIV_NW-1:0]    num_i,
  input  logic [ara_pkg::DIV_DW-1:0]    den_i,
  input  ara_pkg::side_t                side_i,
  output logic                          vld_o,
  output logic [ara_pkg::DIV_DW-1:0]    quo_o,
  output ara_pkg::side_t                side_o
);

  localparam int unsigned DW = ara_pkg::DIV_DW;
  localparam int unsigned NS = ara_pkg::DIV_STAGES;

  logic [NS-1:0]  vld_q;
  logic [DW-1:0]  rem_q [NS];
  logic [DW-1:0]  rem_d [NS];
  logic [DW-1:0]  low_q [NS];
  logic [DW-1:0]  low_d [NS];
  logic [DW-1:0]  quo_q [NS];
  logic [DW-1:0]  quo_d [NS];
  logic [DW-1:0]  den_q [NS];
  logic [DW-1:0]  den_d [NS];
  ara_pkg::side_t side_q [NS];
  ara_pkg::side_t side_d [NS];

  always_comb begin
    logic [DW-1:0] r, l, q, dv;
    logic [DW:0]   t;
    for (int k = 0; k < NS; k++) begin
      // upper half of the numerator is the starting remainder, it stays below den
      r  = (k == 0) ? num_i[ara_pkg::DIV_NW-1:DW] : rem_q[(k == 0) ? 0 : k-1];
      l  = (k == 0) ? num_i[DW-1:0]               : low_q[(k == 0) ? 0 : k-1];
      q  = (k == 0) ? '0                          : quo_q[(k == 0) ? 0 : k-1];
      dv = (k == 0) ? den_i                       : den_q[(k == 0) ? 0 : k-1];
      for (int j = 0; j < ara_pkg::DIV_BPS; j++) begin
        t = {r, l[DW-1]};
        l = {l[DW-2:0], 1'b0};
        if (t >= {1'b0, dv}) begin
          t = t - {1'b0, dv};
          q = {q[DW-2:0], 1'b1};
        end else begin
          q = {q[DW-2:0], 1'b0};
        end
        r = t[DW-1:0];
      end
      rem_d[k]  = r;
      low_d[k]  = l;
      quo_d[k]  = q;
      den_d[k]  = dv;
      side_d[k] = (k == 0) ? side_i : side_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_d[k];
        low_q[k]  <= low_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= den_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign quo_o  = quo_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule
